[rtl/ncs_pkg.sv]
// Package for the nibble CPU step unit.
// Holds the item structs, store geometry and opcode codes; no dependencies.
`default_nettype none

package ncs_pkg;

    // Address and data widths of the nibble store.
    localparam int ADDR_W = 12;
    localparam int NIB_W  = 4;

    // The store covers the addresses below the peripheral window.
    localparam int              STORE_DEPTH = 3072;
    localparam logic [ADDR_W-1:0] PERIPH_BASE = 12'hC00;
    localparam logic [NIB_W-1:0]  NIB_MASK    = 4'hF;
    localparam int              SIGN_IDX    = 3;

    // Action codes of an input item.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Opcodes.
    localparam logic [NIB_W-1:0] OP_MVI  = 4'd0;
    localparam logic [NIB_W-1:0] OP_STA  = 4'd1;
    localparam logic [NIB_W-1:0] OP_LDA  = 4'd2;
    localparam logic [NIB_W-1:0] OP_AD0  = 4'd3;
    localparam logic [NIB_W-1:0] OP_AD1  = 4'd4;
    localparam logic [NIB_W-1:0] OP_ADC  = 4'd5;
    localparam logic [NIB_W-1:0] OP_NAND = 4'd6;
    localparam logic [NIB_W-1:0] OP_NOR  = 4'd7;
    localparam logic [NIB_W-1:0] OP_RRM  = 4'd8;
    localparam logic [NIB_W-1:0] OP_JMP  = 4'd9;
    localparam logic [NIB_W-1:0] OP_JC   = 4'd10;
    localparam logic [NIB_W-1:0] OP_JNC  = 4'd11;
    localparam logic [NIB_W-1:0] OP_JZ   = 4'd12;
    localparam logic [NIB_W-1:0] OP_JNZ  = 4'd13;
    localparam logic [NIB_W-1:0] OP_JM   = 4'd14;
    localparam logic [NIB_W-1:0] OP_JP   = 4'd15;

    // One input item.
    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] load_address;
        logic [NIB_W-1:0]  load_nibble;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [NIB_W-1:0]  opcode;
        logic [ADDR_W-1:0] operand;
        logic [NIB_W-1:0]  accumulator;
        logic              carry_flag;
        logic              store_valid;
        logic [ADDR_W-1:0] store_address;
        logic [NIB_W-1:0]  store_nibble;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/ncs_ram.sv]
// Single-port nibble store with a registered read.
// Depends on ncs_pkg for the depth and widths.
`default_nettype none

module ncs_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ncs_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [ncs_pkg::NIB_W-1:0]  i_wdata,
    output logic      [ncs_pkg::NIB_W-1:0]  o_rdata
);
    import ncs_pkg::*;

    logic [NIB_W-1:0] mem [STORE_DEPTH];

    // Write when enabled; the read is taken first and returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

`default_nettype wire

[rtl/nibble_cpu_step_unit.sv]
// Top level of the nibble CPU step unit: sequencer, registers and execute logic.
// Depends on ncs_pkg and instantiates the single-port store ncs_ram.
//
// A load item is written while idle; busy stays low and the next item may follow at once.
// A step item holds busy through one store read per instruction nibble, the operand
// access (all opcodes but mvi), then execute; the result strobe comes in the same
// cycle as busy falls. The single store port serialises these accesses.
// After reset, busy stays high while the store is cleared.
// Results cannot be stalled; each is shown for exactly one cycle with o_done.
`default_nettype none

module nibble_cpu_step_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ncs_pkg::t_in_item  i_item,
    output logic                    o_done,
    output ncs_pkg::t_out_item      o_result
);
    import ncs_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    localparam logic [2:0] CNT_OP   = 3'd1;
    localparam logic [2:0] CNT_LO   = 3'd2;
    localparam logic [2:0] CNT_MID  = 3'd3;
    localparam logic [2:0] CNT_HI   = 3'd4;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

    logic [1:0]        r_state;
    logic [2:0]        r_cnt;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_pc;
    logic [NIB_W-1:0]  r_acc;
    logic              r_cy;
    logic              r_done;
    logic [NIB_W-1:0]  r_op;
    logic [ADDR_W-1:0] r_arg;
    logic              r_rd_periph;
    t_out_item         r_res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [NIB_W-1:0]  ram_wdata;
    logic [NIB_W-1:0]  ram_q;
    logic [NIB_W-1:0]  rdata;
    logic              accept;

    logic [NIB_W-1:0]  n_acc;
    logic              n_cy;
    logic [ADDR_W-1:0] n_pc;
    logic [NIB_W:0]    sum;
    logic              cin;
    logic              take;
    t_out_item         n_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    // Peripheral reads return all ones.
    assign rdata = r_rd_periph ? NIB_MASK : ram_q;

    // Store port control: clear sweep, load writes, fetches and the operand access.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_pc;
        ram_wdata = r_acc;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_addr  = i_item.load_address;
                ram_wdata = i_item.load_nibble;
                ram_we    = accept && (i_item.action == ACT_LOAD)
                            && (i_item.load_address < PERIPH_BASE);
            end
            S_FETCH: begin
                if (r_cnt == CNT_HI) begin
                    ram_addr = {rdata, r_arg[7:0]};
                    ram_we   = (r_op == OP_STA) && ({rdata, r_arg[7:0]} < PERIPH_BASE);
                end else begin
                    ram_addr = r_pc + ADDR_W'(r_cnt);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ncs_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // Execute: operand nibble arrives from the store in this state.
    always_comb begin
        n_acc = r_acc;
        n_cy  = r_cy;
        cin   = 1'b0;
        take  = 1'b0;
        n_pc  = r_pc + ((r_op == OP_MVI) ? ADDR_W'(2) : ADDR_W'(4));
        if (r_op == OP_AD1) begin
            cin = 1'b1;
        end else if (r_op == OP_ADC) begin
            cin = r_cy;
        end
        sum = {1'b0, r_acc} + {1'b0, rdata} + {{NIB_W{1'b0}}, cin};
        case (r_op)
            OP_MVI:  n_acc = r_arg[NIB_W-1:0];
            OP_STA:  n_acc = r_acc;
            OP_LDA: begin
                n_acc = rdata;
                n_cy  = 1'b0;
            end
            OP_AD0, OP_AD1, OP_ADC: begin
                n_acc = sum[NIB_W-1:0];
                n_cy  = sum[NIB_W];
            end
            OP_NAND: n_acc = ~(r_acc & rdata);
            OP_NOR:  n_acc = ~(r_acc | rdata);
            OP_RRM:  n_acc = rdata >> 1;
            OP_JMP:  take = 1'b1;
            OP_JC:   take = r_cy;
            OP_JNC:  take = !r_cy;
            OP_JZ:   take = (r_acc == '0);
            OP_JNZ:  take = (r_acc != '0);
            OP_JM:   take = r_acc[SIGN_IDX];
            default: take = !r_acc[SIGN_IDX];
        endcase
        if (take) begin
            n_pc = r_arg;
        end
        n_res.next_pc       = n_pc;
        n_res.opcode        = r_op;
        n_res.operand       = r_arg;
        n_res.accumulator   = n_acc;
        n_res.carry_flag    = n_cy;
        n_res.store_valid   = (r_op == OP_STA);
        n_res.store_address = (r_op == OP_STA) ? r_arg : '0;
        n_res.store_nibble  = (r_op == OP_STA) ? r_acc : '0;
    end

    // Control state: sequencer, architectural registers and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_acc   <= '0;
            r_cy    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept && (i_item.action == ACT_STEP)) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if ((r_cnt == CNT_LO) && (r_op == OP_MVI)) begin
                        r_state <= S_EXEC;
                    end else if (r_cnt == CNT_HI) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_pc    <= n_pc;
                    r_acc   <= n_acc;
                    r_cy    <= n_cy;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: fetched instruction, peripheral read flag and the result item.
    always_ff @(posedge i_clk) begin
        r_rd_periph <= (ram_addr >= PERIPH_BASE);
        if (r_state == S_FETCH) begin
            case (r_cnt)
                CNT_OP:  r_op <= rdata;
                CNT_LO:  r_arg <= {{(ADDR_W-NIB_W){1'b0}}, rdata};
                CNT_MID: r_arg[7:4] <= rdata;
                CNT_HI:  r_arg[11:8] <= rdata;
                default: r_op <= r_op;
            endcase
        end
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end
    end

    // Every execute cycle produces exactly one strobed result.
    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("execute did not produce a result strobe");

    // A result is shown for one cycle only.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    // The store is never written inside the peripheral window.
    a_no_periph_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_addr < PERIPH_BASE))
        else $error("store write to a peripheral address");

    // A reported store comes only from a store instruction.
    a_store_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.store_valid) |-> (o_result.opcode == OP_STA))
        else $error("store reported for a non-store opcode");

    // No item is accepted while the clearing sweep runs.
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy)
        else $error("unit not busy during store clear");

endmodule

`default_nettype wire
